// ===== design/deq_pkg.sv =====
// Package for the indexed double-ended queue.
// Holds default sizes, opcode and status codes. No dependencies.
package deq_pkg;

    localparam int DEFAULT_CAPACITY   = 1024;
    localparam int DEFAULT_ITEM_WIDTH = 32;

    localparam int OPCODE_W = 3;
    localparam int STATUS_W = 2;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 10;
    localparam int COUNT_W  = 11;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_READ_POS   = 3'd4
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

endpackage

// ===== design/double_ended_queue_indexed.sv =====
// Indexed double-ended queue over one circular single-port item memory.
// Depends on deq_pkg (sizes, opcode and status codes).
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+-----------------------------------------
//  input   | i_in_valid  | o_in_ready  | i_opcode, i_item_value, i_position
//  output  | o_out_valid | i_out_ready | o_read_value, o_status, o_item_count
//
// Flow: one transaction per cycle while the output is not held; the accept edge
//   captures the memory read data into the read stage, and the result is loaded
//   into the output register when the read stage moves on.
// The front pointer and count are updated at the accept edge, so the next
//   transaction addresses the memory with fresh pointers; a write is visible
//   to the next transaction's read, so no forwarding path is needed.
// Reset: synchronous, active low; clears pointers, count and valid flags.
//   The item memory is not cleared: only entries that were pushed are read.
// Stalls: a held output stalls the read stage, which in turn drops o_in_ready.
module double_ended_queue_indexed #(
    parameter int CAPACITY   = deq_pkg::DEFAULT_CAPACITY,
    parameter int ITEM_WIDTH = deq_pkg::DEFAULT_ITEM_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [deq_pkg::OPCODE_W-1:0]  i_opcode,
    input  logic [deq_pkg::VALUE_W-1:0]   i_item_value,
    input  logic [deq_pkg::POS_W-1:0]     i_position,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [deq_pkg::VALUE_W-1:0]   o_read_value,
    output logic [deq_pkg::STATUS_W-1:0]  o_status,
    output logic [deq_pkg::COUNT_W-1:0]   o_item_count
);
    import deq_pkg::*;

    localparam int PW   = $clog2(CAPACITY);       // slot pointer width
    localparam int CW   = $clog2(CAPACITY + 1);   // count width, holds CAPACITY
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    // Slot that lies off places after base, both below CAPACITY.
    function automatic logic [PW-1:0] slot_add(input logic [PW-1:0] base,
                                               input logic [PW-1:0] off);
        logic [PW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (PW+1)'(CAPACITY)) begin
            sum = sum - (PW+1)'(CAPACITY);
        end
        return sum[PW-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Queue state
    // ------------------------------------------------------------------
    logic [PW-1:0]         r_front, n_front;
    logic [CW-1:0]         r_count, n_count;
    logic [ITEM_WIDTH-1:0] r_mem [CAPACITY];
    logic [ITEM_WIDTH-1:0] r_mem_q;

    // read stage: data arrives in r_mem_q
    logic                  r_s1_valid;
    logic                  r_s1_has_data;
    t_status               r_s1_status;
    logic [CW-1:0]         r_s1_count;

    // output register
    logic                  r_out_valid;
    logic [VALUE_W-1:0]    r_out_value;
    t_status               r_out_status;
    logic [CW-1:0]         r_out_count;

    // handshake
    logic out_free, s1_move, accept;

    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_move    = r_s1_valid && out_free;
    assign o_in_ready = !r_s1_valid || s1_move;
    assign accept     = i_in_valid && o_in_ready;

    // ------------------------------------------------------------------
    // Operation decode: pointer update and memory command
    // ------------------------------------------------------------------
    logic                  full, empty;
    logic                  mem_we, mem_re;
    logic [PW-1:0]         mem_addr;
    logic [ITEM_WIDTH-1:0] wdata;
    logic [63:0]           val_ext;
    logic                  op_has_data;
    t_status               op_status;

    assign full    = (r_count == CW'(CAPACITY));
    assign empty   = (r_count == '0);
    assign val_ext = 64'(i_item_value);
    assign wdata   = val_ext[ITEM_WIDTH-1:0];

    always_comb begin
        n_front     = r_front;
        n_count     = r_count;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_addr    = r_front;
        op_has_data = 1'b0;
        op_status   = ST_OK;
        case (t_opcode'(i_opcode))
            OP_PUSH_FRONT: begin
                if (full) begin
                    op_status = ST_FULL;
                end else begin
                    n_front  = (r_front == '0) ? PW'(CAPACITY - 1) : r_front - PW'(1);
                    mem_addr = n_front;
                    mem_we   = 1'b1;
                    n_count  = r_count + CW'(1);
                end
            end
            OP_PUSH_BACK: begin
                if (full) begin
                    op_status = ST_FULL;
                end else begin
                    mem_addr = slot_add(r_front, PW'(r_count));
                    mem_we   = 1'b1;
                    n_count  = r_count + CW'(1);
                end
            end
            OP_POP_FRONT: begin
                if (empty) begin
                    op_status = ST_EMPTY;
                end else begin
                    mem_addr    = r_front;
                    mem_re      = 1'b1;
                    op_has_data = 1'b1;
                    n_front     = slot_add(r_front, PW'(1));
                    n_count     = r_count - CW'(1);
                end
            end
            OP_POP_BACK: begin
                if (empty) begin
                    op_status = ST_EMPTY;
                end else begin
                    mem_addr    = slot_add(r_front, PW'(r_count - CW'(1)));
                    mem_re      = 1'b1;
                    op_has_data = 1'b1;
                    n_count     = r_count - CW'(1);
                end
            end
            OP_READ_POS: begin
                if (CMPW'(i_position) >= CMPW'(r_count)) begin
                    op_status = ST_EMPTY;
                end else begin
                    mem_addr    = slot_add(r_front, PW'(i_position));
                    mem_re      = 1'b1;
                    op_has_data = 1'b1;
                end
            end
            default: begin
                // unused opcode: no operation
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Item memory: one port, read data registered
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (accept && mem_we) begin
            r_mem[mem_addr] <= wdata;
        end
        if (accept && mem_re) begin
            r_mem_q <= r_mem[mem_addr];
        end
    end

    // ------------------------------------------------------------------
    // Pointers and pipeline control
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_count     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_front <= n_front;
                r_count <= n_count;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    logic [63:0] rd_ext;
    assign rd_ext = 64'(r_mem_q);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_has_data <= op_has_data;
            r_s1_status   <= op_status;
            r_s1_count    <= n_count;
        end
        if (s1_move) begin
            r_out_value  <= r_s1_has_data ? rd_ext[VALUE_W-1:0] : '0;
            r_out_status <= r_s1_status;
            r_out_count  <= r_s1_count;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_out_value;
    assign o_status     = r_out_status;
    assign o_item_count = COUNT_W'(r_out_count);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("item count above capacity");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_free) |-> !o_in_ready)
        else $error("input accepted while read stage is stalled");

    a_stall_holds_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_free) |=> $stable(r_mem_q))
        else $error("read data changed while read stage is stalled");

    a_refused_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && full && (i_opcode == OP_PUSH_FRONT || i_opcode == OP_PUSH_BACK))
        |=> ($stable(r_count) && $stable(r_front) && r_s1_status == ST_FULL))
        else $error("push into full queue changed state");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !empty && (i_opcode == OP_POP_FRONT || i_opcode == OP_POP_BACK))
        |=> (r_count == $past(r_count) - CW'(1)))
        else $error("pop did not decrement count");

endmodule
